### rtl/core/clgl_pkg.sv
`default_nettype none

package clgl_pkg;

    localparam int MAP_COUNT     = 4;
    localparam int STOP_TOTAL    = 17;
    localparam int STOP_IDX_BITS = 5;
    localparam int STOP_DENOM    = 5100;
    localparam int SEL_BITS      = 3;
    localparam int MAP_BITS      = 2;
    localparam int NM1_BITS      = 3;

    typedef logic [STOP_IDX_BITS-1:0] stop_idx_t;
    typedef logic [12:0]              stop_raw_t;

    typedef struct packed {
        logic valid;
        logic bad;
    } stage_ctrl_t;

    // stop channels in units of 1/5100
    localparam stop_raw_t STOP_TABLE [STOP_TOTAL][3] = '{
        '{13'd1020, 13'd1020, 13'd3570}, '{13'd510,  13'd3060, 13'd1020},
        '{13'd4590, 13'd4080, 13'd1020}, '{13'd4590, 13'd1020, 13'd1020},
        '{13'd4590, 13'd4590, 13'd4590},
        '{13'd1020, 13'd1020, 13'd3570}, '{13'd1020, 13'd2550, 13'd3060},
        '{13'd3570, 13'd2040, 13'd1530},
        '{13'd0,    13'd1500, 13'd5100}, '{13'd5100, 13'd0,    13'd0},
        '{13'd4590, 13'd510,  13'd510},  '{13'd5100, 13'd2550, 13'd510},
        '{13'd4080, 13'd4590, 13'd510},  '{13'd510,  13'd4590, 13'd510},
        '{13'd510,  13'd510,  13'd5100}, '{13'd2550, 13'd1020, 13'd5100},
        '{13'd4590, 13'd1020, 13'd2550}
    };

    localparam stop_idx_t MAP_FIRST [MAP_COUNT] = '{5'd0, 5'd5, 5'd8, 5'd10};
    localparam logic [NM1_BITS-1:0] MAP_STOPS_M1 [MAP_COUNT] =
        '{3'd4, 3'd2, 3'd1, 3'd6};

    // rounded half up to an unsigned channel of cbits bits
    function automatic logic [31:0] stop_chan(input int idx, input int ch, input int cbits);
        longint v;
        longint m;
        v = longint'(STOP_TABLE[idx][ch]);
        m = (longint'(1) << cbits) - 1;
        return 32'((v * m + STOP_DENOM / 2) / STOP_DENOM);
    endfunction

endpackage

`default_nettype wire

### rtl/core/clgl_index.sv
`default_nettype none

module clgl_index #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [clgl_pkg::SEL_BITS-1:0] map_select,
    input  wire logic [FRACTION_BITS:0]       position,
    output clgl_pkg::stage_ctrl_t             ctrl,
    output clgl_pkg::stop_idx_t               stop_idx,
    output logic [FRACTION_BITS-1:0]          frac
);
    import clgl_pkg::*;

    localparam int F = FRACTION_BITS;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    stage_ctrl_t         ctrl1_reg, ctrl1_next;
    logic                one1_reg;
    logic [MAP_BITS-1:0] map1_reg;
    logic [F:0]          pos1_reg;

    stage_ctrl_t         ctrl2_reg;
    stop_idx_t           idx2_reg, idx2_next;
    logic [F-1:0]        frac2_reg, frac2_next;

    logic [F+NM1_BITS:0] scaled;
    stop_idx_t           first;
    logic [NM1_BITS-1:0] nm1;

    always_comb
    begin
        ctrl1_next.valid = start;
        ctrl1_next.bad   = (map_select >= SEL_BITS'(MAP_COUNT)) || (position > ONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end
        else
        begin
            ctrl1_reg <= ctrl1_next;
            ctrl2_reg <= ctrl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        one1_reg  <= (position == ONE);
        map1_reg  <= map_select[MAP_BITS-1:0];
        pos1_reg  <= position;
        idx2_reg  <= idx2_next;
        frac2_reg <= frac2_next;
    end

    always_comb
    begin
        first  = MAP_FIRST[map1_reg];
        nm1    = MAP_STOPS_M1[map1_reg];
        scaled = {{NM1_BITS{1'b0}}, pos1_reg} * {{(F+1){1'b0}}, nm1};
        if (ctrl1_reg.bad)
        begin
            idx2_next  = '0;
            frac2_next = '0;
        end
        else if (one1_reg)
        begin
            idx2_next  = first + STOP_IDX_BITS'(nm1);
            frac2_next = '0;
        end
        else
        begin
            idx2_next  = first + STOP_IDX_BITS'(scaled[F+NM1_BITS:F]);
            frac2_next = scaled[F-1:0];
        end
    end

    assign ctrl     = ctrl2_reg;
    assign stop_idx = idx2_reg;
    assign frac     = frac2_reg;

endmodule

`default_nettype wire

### rtl/core/clgl_fetch.sv
`default_nettype none

module clgl_fetch #(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire clgl_pkg::stage_ctrl_t         ctrl_in,
    input  wire clgl_pkg::stop_idx_t           stop_idx,
    input  wire logic [FRACTION_BITS-1:0]      frac_in,
    output clgl_pkg::stage_ctrl_t              ctrl_out,
    output logic [2:0][CHANNEL_BITS-1:0]       lo_color,
    output logic [2:0][CHANNEL_BITS-1:0]       hi_color,
    output logic [FRACTION_BITS-1:0]           frac_out
);
    import clgl_pkg::*;

    logic [2:0][CHANNEL_BITS-1:0] stop_color [STOP_TOTAL];

    for (genvar s = 0; s < STOP_TOTAL; s++)
    begin : g_stop
        for (genvar c = 0; c < 3; c++)
        begin : g_chan
            assign stop_color[s][c] = CHANNEL_BITS'(stop_chan(s, c, CHANNEL_BITS));
        end
    end

    stage_ctrl_t                  ctrl_reg;
    logic [2:0][CHANNEL_BITS-1:0] lo_reg, hi_reg;
    logic [FRACTION_BITS-1:0]     frac_reg;
    stop_idx_t                    hi_idx;

    // last stop of the table pairs with itself
    assign hi_idx = (stop_idx == STOP_IDX_BITS'(STOP_TOTAL - 1)) ?
                    stop_idx : stop_idx + STOP_IDX_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= stop_color[stop_idx];
        hi_reg   <= stop_color[hi_idx];
        frac_reg <= frac_in;
    end

    assign ctrl_out = ctrl_reg;
    assign lo_color = lo_reg;
    assign hi_color = hi_reg;
    assign frac_out = frac_reg;

endmodule

`default_nettype wire

### rtl/core/clgl_blend.sv
`default_nettype none

module clgl_blend #(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire clgl_pkg::stage_ctrl_t         ctrl_in,
    input  wire logic [2:0][CHANNEL_BITS-1:0]  lo_color,
    input  wire logic [2:0][CHANNEL_BITS-1:0]  hi_color,
    input  wire logic [FRACTION_BITS-1:0]      frac,
    output clgl_pkg::stage_ctrl_t              ctrl_out,
    output logic [2:0][CHANNEL_BITS-1:0]       color
);
    import clgl_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int CB = CHANNEL_BITS;
    localparam int PW = CB + F + 1;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    stage_ctrl_t        ctrl4_reg, ctrl5_reg;
    logic [2:0][PW-1:0] plo_reg, phi_reg;
    logic [2:0][CB-1:0] color_reg, color_next;
    logic [F:0]         w_lo;
    logic [2:0][PW-1:0] plo_next, phi_next;
    logic [2:0][PW-1:0] sum;

    always_comb
    begin
        w_lo = ONE - {1'b0, frac};
        for (int c = 0; c < 3; c++)
        begin
            plo_next[c] = PW'(lo_color[c]) * PW'(w_lo);
            phi_next[c] = PW'(hi_color[c]) * PW'(frac);
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c]        = plo_reg[c] + phi_reg[c];
            color_next[c] = sum[c][F+CB-1:F];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl4_reg <= '0;
            ctrl5_reg <= '0;
        end
        else
        begin
            ctrl4_reg <= ctrl_in;
            ctrl5_reg <= ctrl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        color_reg <= color_next;
    end

    assign ctrl_out = ctrl5_reg;
    assign color    = color_reg;

endmodule

`default_nettype wire

### rtl/core/colormap_gradient_lerp_core.sv
`default_nettype none
// result_valid, bad_request and the colour are driven from the output register of the last stage
// throughput: one request per cycle, fixed five-stage pipeline
// two index stages, table fetch, multiply, then add into the output register
// busy stays low and the receiver cannot stall, so nothing ever holds back
// reset: asynchronous active low, clears all valid bits; no request in flight

module colormap_gradient_lerp_core #(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [clgl_pkg::SEL_BITS-1:0] map_select,
    input  wire logic [FRACTION_BITS:0]        position,
    output logic                               result_valid,
    output logic [CHANNEL_BITS-1:0]            red,
    output logic [CHANNEL_BITS-1:0]            green,
    output logic [CHANNEL_BITS-1:0]            blue,
    output logic                               bad_request
);
    import clgl_pkg::*;

    stage_ctrl_t                  ctrl_idx, ctrl_fetch, ctrl_out;
    stop_idx_t                    stop_idx;
    logic [FRACTION_BITS-1:0]     frac_idx, frac_fetch;
    logic [2:0][CHANNEL_BITS-1:0] lo_color, hi_color, color;

    assign busy = 1'b0;

    clgl_index #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start & ~busy),
        .map_select(map_select),
        .position  (position),
        .ctrl      (ctrl_idx),
        .stop_idx  (stop_idx),
        .frac      (frac_idx)
    );

    clgl_fetch #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_fetch (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl_in (ctrl_idx),
        .stop_idx(stop_idx),
        .frac_in (frac_idx),
        .ctrl_out(ctrl_fetch),
        .lo_color(lo_color),
        .hi_color(hi_color),
        .frac_out(frac_fetch)
    );

    clgl_blend #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl_in (ctrl_fetch),
        .lo_color(lo_color),
        .hi_color(hi_color),
        .frac    (frac_fetch),
        .ctrl_out(ctrl_out),
        .color   (color)
    );

    assign result_valid = ctrl_out.valid;
    assign bad_request  = ctrl_out.bad;
    assign red          = color[0];
    assign green        = color[1];
    assign blue         = color[2];

endmodule

`default_nettype wire
